FILE: hdl/sfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types, codes and default sizes of the sprite frame sequencer
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int unsigned NUM_ANIMATIONS_DEF       = 16;
  localparam int unsigned FRAMES_PER_ANIMATION_DEF = 16;
  localparam int unsigned TIME_BITS_DEF            = 16;

  // operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_LINK = 2'd2;
  localparam logic [1:0] OP_PLAY = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  anim_id;
    logic [15:0] delta_time;
    logic [15:0] frame_duration;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [15:0] image_ref;
    logic [3:0]  link_target;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  current_animation;
    logic [3:0]  current_frame;
    logic        size_changed;
    logic [11:0] shown_width;
    logic [11:0] shown_height;
    logic [15:0] shown_image;
    logic        mirrored;
    logic        frame_valid;
  } out_item_t;

  // one stored frame
  typedef struct packed {
    logic [15:0] duration;
    logic [11:0] width;
    logic [11:0] height;
    logic [15:0] image;
  } frame_entry_t;

  localparam int unsigned ENTRY_BITS = $bits(frame_entry_t);

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_EXEC = 3'b010,
    FSM_RESP = 3'b100
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic resp;
    logic load_out;
  } ctrl_cmd_t;

endpackage

FILE: hdl/sprite_frame_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_core
// sprite animation sequencer: frame lists, links and frame timing
// ----------------------------------------------------------------------------
// One operation (tick, push frame, set link, play) is taken at a time and
// answered with exactly one result. With the result side free, an item goes
// from its transfer to the next free input in order through capture, the
// update of the lists and playback state that issues the frame store read,
// and the registered read of the frame store before the result is
// registered. A result waiting on the output does not hold up the next
// transfer in; only the response step waits for the result register. The
// frame store is a plain memory with no reset; only entries below an
// animation's frame count are ever shown. The flip setting may be written
// while the block is idle and is echoed in every result as mirrored.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_core #(
  parameter int unsigned NUM_ANIMATIONS       = sfs_pkg::NUM_ANIMATIONS_DEF,
  parameter int unsigned FRAMES_PER_ANIMATION = sfs_pkg::FRAMES_PER_ANIMATION_DEF,
  parameter int unsigned TIME_BITS            = sfs_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // operation transfer
  input  logic               in_valid,
  output logic               in_stall,
  input  sfs_pkg::in_item_t  in_data,
  // result transfer
  output logic               out_valid,
  input  logic               out_stall,
  output sfs_pkg::out_item_t out_data,
  // flip setting
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  sfs_pkg::ctrl_cmd_t cmd;

  // sequencing of each item
  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // lists, links, playback state and the result register
  sfs_datapath #(
    .NUM_ANIMATIONS       (NUM_ANIMATIONS),
    .FRAMES_PER_ANIMATION (FRAMES_PER_ANIMATION),
    .TIME_BITS            (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

FILE: hdl/sfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/sfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_ctrl
// sequencing of one item: capture, execute, respond
// ----------------------------------------------------------------------------
module sfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sfs_pkg::ctrl_cmd_t cmd
);

  sfs_pkg::fsm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture  = (state_r == sfs_pkg::FSM_IDLE) && in_valid;
    cmd.exec     = (state_r == sfs_pkg::FSM_EXEC);
    cmd.resp     = (state_r == sfs_pkg::FSM_RESP);
    // result register free or being emptied this cycle
    cmd.load_out = cmd.resp && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfs_pkg::FSM_IDLE: begin
        if (in_valid) state_nxt = sfs_pkg::FSM_EXEC;
      end
      sfs_pkg::FSM_EXEC: begin
        state_nxt = sfs_pkg::FSM_RESP;
      end
      sfs_pkg::FSM_RESP: begin
        if (cmd.load_out) state_nxt = sfs_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = sfs_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfs_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != sfs_pkg::FSM_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hdl/sfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_datapath
// frame lists, links, playback state and result register
// ----------------------------------------------------------------------------
module sfs_datapath #(
  parameter int unsigned NUM_ANIMATIONS       = sfs_pkg::NUM_ANIMATIONS_DEF,
  parameter int unsigned FRAMES_PER_ANIMATION = sfs_pkg::FRAMES_PER_ANIMATION_DEF,
  parameter int unsigned TIME_BITS            = sfs_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfs_pkg::ctrl_cmd_t cmd,
  input  sfs_pkg::in_item_t  in_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output sfs_pkg::out_item_t out_data
);

  localparam int unsigned AW    = $clog2(NUM_ANIMATIONS);
  localparam int unsigned IW    = ((AW > 4) ? AW : 4) + 1;
  localparam int unsigned FW    = (FRAMES_PER_ANIMATION > 1) ?
                                  $clog2(FRAMES_PER_ANIMATION) : 1;
  localparam int unsigned FXW   = (FW > 4) ? FW : 4;
  localparam int unsigned CNTW  = $clog2(FRAMES_PER_ANIMATION + 1);
  localparam int unsigned DEPTH = NUM_ANIMATIONS * FRAMES_PER_ANIMATION;
  localparam int unsigned ADW   = $clog2(DEPTH);
  localparam int unsigned CW    = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int unsigned SW    = CW + 1;

  function automatic logic [ADW-1:0] entry_addr(input logic [AW-1:0] a,
                                                input logic [FW-1:0] f);
    entry_addr = ADW'(a) * ADW'(FRAMES_PER_ANIMATION) + ADW'(f);
  endfunction

  // item and state registers
  sfs_pkg::in_item_t     in_r;
  logic [CNTW-1:0]       count_r  [NUM_ANIMATIONS];
  logic [CNTW-1:0]       count_nxt[NUM_ANIMATIONS];
  logic                  lvalid_r [NUM_ANIMATIONS];
  logic                  lvalid_nxt[NUM_ANIMATIONS];
  logic [3:0]            ltgt_r   [NUM_ANIMATIONS];
  logic [3:0]            ltgt_nxt [NUM_ANIMATIONS];
  logic [AW-1:0]         pa_r, pa_nxt;
  logic [FW-1:0]         pf_r, pf_nxt;
  logic [TIME_BITS-1:0]  timer_r, timer_nxt;
  logic [CNTW-1:0]       cur_cnt_r, cur_cnt_nxt;
  sfs_pkg::frame_entry_t cache_r, cache_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  changed_r, changed_nxt;
  logic                  flip_r;
  sfs_pkg::out_item_t    out_r;

  // frame store
  logic                  ram_we, ram_re;
  logic [ADW-1:0]        ram_waddr, ram_raddr;
  sfs_pkg::frame_entry_t ram_wdata, ram_rdata;

  sfs_ram #(
    .WIDTH (sfs_pkg::ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // decode of the held item
  logic [IW-1:0]   id_ext, tgt_ext;
  logic [AW-1:0]   id_idx, tgt_idx, sel_idx;
  logic            id_ok, tgt_ok, link_go;
  logic [CNTW-1:0] cnt_sel, nf;
  logic [SW-1:0]   sum;
  logic [CW-1:0]   timer_w, dur_w;

  always_comb begin
    id_ext  = IW'(in_r.anim_id);
    id_idx  = id_ext[AW-1:0];
    id_ok   = id_ext < IW'(NUM_ANIMATIONS);
    tgt_ext = IW'(ltgt_r[pa_r]);
    tgt_idx = tgt_ext[AW-1:0];
    tgt_ok  = tgt_ext < IW'(NUM_ANIMATIONS);
    // one count read a cycle: link target for a tick, addressed list otherwise
    sel_idx = (in_r.operation == sfs_pkg::OP_TICK) ? tgt_idx : id_idx;
    cnt_sel = (IW'(sel_idx) < IW'(NUM_ANIMATIONS)) ? count_r[sel_idx] : '0;
    link_go = lvalid_r[pa_r] && tgt_ok && (cnt_sel != '0);
    nf      = CNTW'(pf_r) + CNTW'(1);
    timer_w = CW'(timer_r);
    dur_w   = CW'(cache_r.duration);
    sum     = SW'(timer_r) + SW'(in_r.delta_time);
  end

  always_comb begin
    count_nxt   = count_r;
    lvalid_nxt  = lvalid_r;
    ltgt_nxt    = ltgt_r;
    pa_nxt      = pa_r;
    pf_nxt      = pf_r;
    timer_nxt   = timer_r;
    cur_cnt_nxt = cur_cnt_r;
    cache_nxt   = cache_r;
    rd_pend_nxt = rd_pend_r;
    status_nxt  = status_r;
    changed_nxt = changed_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = entry_addr(id_idx, cnt_sel[FW-1:0]);
    ram_wdata   = '{duration: in_r.frame_duration, width: in_r.frame_width,
                    height: in_r.frame_height, image: in_r.image_ref};

    if (cmd.exec) begin
      status_nxt  = sfs_pkg::ST_DONE;
      changed_nxt = 1'b0;
      rd_pend_nxt = 1'b0;
      case (in_r.operation)
        sfs_pkg::OP_TICK: begin
          if (cur_cnt_r == '0) begin
            status_nxt = sfs_pkg::ST_IGNORED;
          end else if (timer_w < dur_w) begin
            // saturating timer
            if (|sum[SW-1:TIME_BITS]) timer_nxt = '1;
            else                      timer_nxt = sum[TIME_BITS-1:0];
          end else begin
            timer_nxt   = '0;
            changed_nxt = 1'b1;
            rd_pend_nxt = 1'b1;
            if (nf >= cur_cnt_r) begin
              pf_nxt = '0;
              if (link_go) begin
                pa_nxt      = tgt_idx;
                cur_cnt_nxt = cnt_sel;
              end
            end else begin
              pf_nxt = nf[FW-1:0];
            end
          end
        end
        sfs_pkg::OP_PUSH: begin
          if (!id_ok) begin
            status_nxt = sfs_pkg::ST_IGNORED;
          end else if (cnt_sel >= CNTW'(FRAMES_PER_ANIMATION)) begin
            status_nxt = sfs_pkg::ST_FULL;
          end else begin
            ram_we            = 1'b1;
            count_nxt[id_idx] = cnt_sel + CNTW'(1);
            if (id_idx == pa_r) begin
              cur_cnt_nxt = cur_cnt_r + CNTW'(1);
              // first frame of the playing list becomes the shown frame
              if (cur_cnt_r == '0) cache_nxt = ram_wdata;
            end
          end
        end
        sfs_pkg::OP_LINK: begin
          if (!id_ok) begin
            status_nxt = sfs_pkg::ST_IGNORED;
          end else begin
            lvalid_nxt[id_idx] = 1'b1;
            ltgt_nxt[id_idx]   = in_r.link_target;
          end
        end
        sfs_pkg::OP_PLAY: begin
          if (!id_ok || (id_idx == pa_r) || (cnt_sel == '0)) begin
            status_nxt = sfs_pkg::ST_IGNORED;
          end else begin
            pa_nxt      = id_idx;
            pf_nxt      = '0;
            timer_nxt   = '0;
            cur_cnt_nxt = cnt_sel;
            rd_pend_nxt = 1'b1;
          end
        end
        default: begin
          status_nxt = sfs_pkg::ST_IGNORED;
        end
      endcase
      ram_re = rd_pend_nxt;
    end

    if (cmd.resp && rd_pend_r) begin
      cache_nxt = ram_rdata;
    end
  end

  assign ram_raddr = entry_addr(pa_nxt, pf_nxt);

  // result formation
  sfs_pkg::frame_entry_t shown;
  logic [IW-1:0]         pa_ext;
  logic [FXW-1:0]        pf_ext;
  logic                  has_frames;

  always_comb begin
    shown      = rd_pend_r ? ram_rdata : cache_r;
    has_frames = (cur_cnt_r != '0);
    pa_ext     = IW'(pa_r);
    pf_ext     = FXW'(pf_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    cache_r <= cache_nxt;
    if (cmd.load_out) begin
      out_r.status            <= status_r;
      out_r.current_animation <= pa_ext[3:0];
      out_r.current_frame     <= pf_ext[3:0];
      out_r.size_changed      <= changed_r;
      out_r.shown_width       <= has_frames ? shown.width  : 12'd0;
      out_r.shown_height      <= has_frames ? shown.height : 12'd0;
      out_r.shown_image       <= has_frames ? shown.image  : 16'd0;
      out_r.mirrored          <= flip_r;
      out_r.frame_valid       <= has_frames;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ANIMATIONS; i++) begin
        count_r[i]  <= '0;
        lvalid_r[i] <= 1'b0;
        ltgt_r[i]   <= '0;
      end
      pa_r      <= '0;
      pf_r      <= '0;
      timer_r   <= '0;
      cur_cnt_r <= '0;
      rd_pend_r <= 1'b0;
      status_r  <= sfs_pkg::ST_DONE;
      changed_r <= 1'b0;
      flip_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      lvalid_r  <= lvalid_nxt;
      ltgt_r    <= ltgt_nxt;
      pa_r      <= pa_nxt;
      pf_r      <= pf_nxt;
      timer_r   <= timer_nxt;
      cur_cnt_r <= cur_cnt_nxt;
      rd_pend_r <= rd_pend_nxt;
      status_r  <= status_nxt;
      changed_r <= changed_nxt;
      if (cfg_wr_en) flip_r <= cfg_wr_data;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/sfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_checker
// port-level checks of the sprite frame sequencer
// ----------------------------------------------------------------------------
module sfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sfs_pkg::out_item_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: input is stalled right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // no frames means nothing shown
  a_empty_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_valid |->
      out_data.shown_width == 12'd0 && out_data.shown_height == 12'd0 &&
      out_data.shown_image == 16'd0)
    else $error("shown frame without frames");

  // a frame advance is always a completed tick on a list with frames
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.size_changed |->
      out_data.status == sfs_pkg::ST_DONE && out_data.frame_valid)
    else $error("frame advance with bad status");

endmodule

bind sprite_frame_sequencer_core sfs_checker u_sfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: verif/sfs_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_result_checker
// watches both transfer channels of the sprite frame sequencer, predicts each
// result from its own copy of the frame lists and playback state, and
// compares every result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module sfs_result_checker
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned ANIMS  = NUM_ANIMATIONS_DEF;
  localparam int unsigned FRAMES = FRAMES_PER_ANIMATION_DEF;

  // predicted block state
  frame_entry_t frames [ANIMS][FRAMES];
  logic [4:0]   n_frames [ANIMS];
  logic         link_set [ANIMS];
  logic [3:0]   link_to  [ANIMS];
  logic [3:0]   cur_anim;
  logic [3:0]   cur_frame;
  logic [15:0]  timer;
  logic         flip;

  out_item_t predicted_frames[$];

  function automatic out_item_t step_sequencer(in_item_t op);
    out_item_t    r;
    frame_entry_t fe;
    logic [16:0]  sum;
    logic [3:0]   tgt;
    r = '0;
    r.status = ST_DONE;
    case (op.operation)
      OP_TICK: begin
        if (n_frames[cur_anim] == 0) begin
          r.status = ST_IGNORED;
        end else begin
          fe = frames[cur_anim][cur_frame];
          if (timer < fe.duration) begin
            // timer saturates at full scale
            sum   = {1'b0, timer} + {1'b0, op.delta_time};
            timer = sum[16] ? 16'hFFFF : sum[15:0];
          end else begin
            timer = '0;
            r.size_changed = 1'b1;
            if ({1'b0, cur_frame} + 5'd1 >= n_frames[cur_anim]) begin
              cur_frame = '0;
              tgt = link_to[cur_anim];
              if (link_set[cur_anim] && n_frames[tgt] != 0) cur_anim = tgt;
            end else begin
              cur_frame = cur_frame + 4'd1;
            end
          end
        end
      end
      OP_PUSH: begin
        if (n_frames[op.anim_id] >= FRAMES) begin
          r.status = ST_FULL;
        end else begin
          frames[op.anim_id][n_frames[op.anim_id][3:0]] =
            '{op.frame_duration, op.frame_width, op.frame_height, op.image_ref};
          n_frames[op.anim_id] = n_frames[op.anim_id] + 5'd1;
        end
      end
      OP_LINK: begin
        link_set[op.anim_id] = 1'b1;
        link_to[op.anim_id]  = op.link_target;
      end
      OP_PLAY: begin
        if (op.anim_id == cur_anim || n_frames[op.anim_id] == 0) begin
          r.status = ST_IGNORED;
        end else begin
          timer     = '0;
          cur_frame = '0;
          cur_anim  = op.anim_id;
        end
      end
    endcase
    r.current_animation = cur_anim;
    r.current_frame     = cur_frame;
    if (n_frames[cur_anim] != 0) begin
      fe = frames[cur_anim][cur_frame];
      r.shown_width  = fe.width;
      r.shown_height = fe.height;
      r.shown_image  = fe.image;
      r.frame_valid  = 1'b1;
    end
    r.mirrored = flip;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int a = 0; a < ANIMS; a++) begin
        n_frames[a] = '0;
        link_set[a] = 1'b0;
        link_to[a]  = '0;
      end
      cur_anim  = '0;
      cur_frame = '0;
      timer     = '0;
      flip      = 1'b0;
      predicted_frames.delete();
    end else begin
      if (cfg_wr_en) flip = cfg_wr_data;
      if (in_valid && !in_stall) begin
        predicted_frames = {predicted_frames, step_sequencer(in_data)};
      end
      if (out_valid && !out_stall) begin
        if (predicted_frames.size() == 0) begin
          $error("result transfer with no prediction outstanding");
          fail_count++;
        end else begin
          want = predicted_frames.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("current_animation", want.current_animation,
                      out_data.current_animation);
          check_field("current_frame", want.current_frame, out_data.current_frame);
          check_field("size_changed", want.size_changed, out_data.size_changed);
          check_field("shown_width", want.shown_width, out_data.shown_width);
          check_field("shown_height", want.shown_height, out_data.shown_height);
          check_field("shown_image", want.shown_image, out_data.shown_image);
          check_field("mirrored", want.mirrored, out_data.mirrored);
          check_field("frame_valid", want.frame_valid, out_data.frame_valid);
        end
      end
    end
    pending = predicted_frames.size();
  end

endmodule

FILE: verif/sprite_frame_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_core_tb
// stimulus and verdict for the sprite frame sequencer: a directed pass over
// empty lists, extreme frame fields, a timer at full scale, wrap and link follow,
// then random phases of ticks, pushes, links and plays with the flip setting
// changed between phases; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_core_tb;
  import sfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200_000;
  localparam int unsigned PHASE_ITEMS     = 460;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned IDLE_PERCENT    = 14;
  localparam int unsigned SETTLE_CYCLES   = 8;
  // transfer numbers between which neither side idles
  localparam int unsigned QUIET_FIRST     = 700;
  localparam int unsigned QUIET_LAST      = 1000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;

  sprite_frame_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sfs_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no idling on either side inside the quiet window
  function automatic logic quiet_window();
    return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
  endfunction

  // result side stalls at random, never in the quiet window
  always @(posedge clk) begin
    out_stall <= !quiet_window() && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // watchdog: a hang or a lost result ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic in_item_t make_op(logic [1:0] op, logic [3:0] id,
                                       logic [15:0] delta, logic [15:0] dur,
                                       logic [11:0] w, logic [11:0] h,
                                       logic [15:0] img, logic [3:0] tgt);
    in_item_t it;
    it = '{op, id, delta, dur, w, h, img, tgt};
    return it;
  endfunction

  // mostly ticks with short durations so frames advance, wraps and links
  // get followed; occasional full-scale values reach timer saturation
  function automatic in_item_t random_op();
    in_item_t    it;
    int unsigned pick;
    it.anim_id        = 4'($urandom_range(0, 15));
    it.frame_width    = 12'($urandom);
    it.frame_height   = 12'($urandom);
    it.image_ref      = 16'($urandom);
    it.link_target    = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 30)      it.delta_time = 16'($urandom);
    else if (pick < 40) it.delta_time = '0;
    else                it.delta_time = 16'($urandom_range(1, 8));
    pick = $urandom_range(0, 99);
    if (pick < 15)      it.frame_duration = 16'hFFFF;
    else if (pick < 25) it.frame_duration = '0;
    else if (pick < 40) it.frame_duration = 16'($urandom);
    else                it.frame_duration = 16'($urandom_range(1, 10));
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.operation = OP_TICK;
    else if (pick < 70) it.operation = OP_PUSH;
    else if (pick < 80) it.operation = OP_LINK;
    else                it.operation = OP_PLAY;
    return it;
  endfunction

  // one transfer in; valid stays up between back-to-back items
  task automatic send_op(input in_item_t it);
    logic taken;
    while (!quiet_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent_count++;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_flip(input logic value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_flip(1'b1);

    // empty lists: tick and play are both ignored
    send_op(make_op(OP_TICK, 4'd0, 16'd5, '0, '0, '0, '0, '0));
    send_op(make_op(OP_PLAY, 4'd5, '0, '0, '0, '0, '0, '0));
    // link to an animation that has no frames yet
    send_op(make_op(OP_LINK, 4'd0, '0, '0, '0, '0, '0, 4'd7));
    // extreme frame fields on animation 0
    send_op(make_op(OP_PUSH, 4'd0, '0, 16'd0, 12'hFFF, 12'h000, 16'hFFFF, 4'hF));
    send_op(make_op(OP_PUSH, 4'd0, '0, 16'hFFFF, 12'h000, 12'hFFF, 16'h0000, 4'h0));
    // zero duration: the first tick advances at once
    send_op(make_op(OP_TICK, 4'd0, 16'd1, '0, '0, '0, '0, '0));
    // full-scale delta fills the timer; the next tick wraps on a link to an empty target and stays on animation 0
    send_op(make_op(OP_TICK, 4'd0, 16'hFFFF, '0, '0, '0, '0, '0));
    send_op(make_op(OP_TICK, 4'd0, 16'hFFFF, '0, '0, '0, '0, '0));
    // advance to frame 1, then give animation 15 a frame and link animation 0 to it
    send_op(make_op(OP_TICK, 4'd0, 16'd1, '0, '0, '0, '0, '0));
    send_op(make_op(OP_PUSH, 4'd15, '0, 16'd1, 12'd1, 12'd1, 16'd1, '0));
    send_op(make_op(OP_LINK, 4'd0, '0, '0, '0, '0, '0, 4'd15));
    // playing the current animation is ignored
    send_op(make_op(OP_PLAY, 4'd0, '0, '0, '0, '0, '0, '0));
    send_op(make_op(OP_TICK, 4'd0, 16'd100, '0, '0, '0, '0, '0));
    send_op(make_op(OP_TICK, 4'd0, 16'd100, '0, '0, '0, '0, '0));
    send_op(make_op(OP_PLAY, 4'd15, '0, '0, '0, '0, '0, '0));
    send_op(make_op(OP_PLAY, 4'd15, '0, '0, '0, '0, '0, '0));
    send_op(make_op(OP_TICK, 4'd0, 16'd0, '0, '0, '0, '0, '0));
    send_op(make_op(OP_TICK, 4'd0, 16'hFFFF, '0, '0, '0, '0, '0));
    // wrap on animation 15 with no link set
    send_op(make_op(OP_TICK, 4'd0, 16'd2, '0, '0, '0, '0, '0));
    send_op(make_op(OP_LINK, 4'd15, '0, '0, '0, '0, '0, 4'd0));
    send_op(make_op(OP_TICK, 4'd0, 16'd3, '0, '0, '0, '0, '0));
    // wrap that follows the link back to animation 0
    send_op(make_op(OP_TICK, 4'd0, 16'd3, '0, '0, '0, '0, '0));

    // random phases; the flip setting alternates between its two values
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      write_flip(ph[0] ? 1'b1 : 1'b0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) send_op(random_op());
    end

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
